// ===== hw/rtl/hrrr_pkg.sv =====
package hrrr_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_ROUTE  = 2'd2,
    REQ_HEALTH = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NO_HEALTHY = 3'd3,
    ST_BAD_INDEX  = 3'd4
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] host_addr;
    logic [15:0] host_port;
    logic [3:0]  entry_index;
    logic        is_healthy;
  } req_word_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] chosen_addr;
    logic [15:0] chosen_port;
    logic [3:0]  chosen_index;
    logic [31:0] chosen_connections;
    logic [4:0]  healthy_total;
    logic [4:0]  entry_total;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_REMOVE,
    S_MOD,
    S_ROUTE,
    S_HEALTH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUB,
    OP_NEXT,
    OP_WRAP,
    OP_ADD,
    OP_HEALTH,
    OP_DELETE,
    OP_PICK,
    OP_FAIL
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e fail_code;
  } dp_cmd_t;

  typedef struct packed {
    logic out_ready;
    logic is_full;
    logic occ_zero;
    logic idx_ge_occ;
    logic scan_done;
    logic hit_match;
    logic hit_healthy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/hrrr_ctrl.sv =====
module hrrr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  hrrr_pkg::req_type_e req_type_i,
  input  hrrr_pkg::dp_stat_t stat_i,
  output hrrr_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);
  import hrrr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, fail_code: ST_OK};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          unique case (req_type_i)
            REQ_ADD:    state_d = S_ADD;
            REQ_REMOVE: state_d = S_REMOVE;
            REQ_ROUTE:  state_d = S_MOD;
            REQ_HEALTH: state_d = S_HEALTH;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (stat_i.out_ready) begin
          if (stat_i.is_full) begin
            cmd_o = '{op: OP_FAIL, fail_code: ST_FULL};
          end else begin
            cmd_o.op = OP_ADD;
          end
          state_d = S_IDLE;
        end
      end
      S_HEALTH: begin
        if (stat_i.out_ready) begin
          if (stat_i.idx_ge_occ) begin
            cmd_o = '{op: OP_FAIL, fail_code: ST_BAD_INDEX};
          end else begin
            cmd_o.op = OP_HEALTH;
          end
          state_d = S_IDLE;
        end
      end
      S_REMOVE: begin
        if (stat_i.idx_ge_occ) begin
          if (stat_i.out_ready) begin
            cmd_o   = '{op: OP_FAIL, fail_code: ST_NOT_FOUND};
            state_d = S_IDLE;
          end
        end else if (stat_i.hit_match) begin
          if (stat_i.out_ready) begin
            cmd_o.op = OP_DELETE;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_NEXT;
        end
      end
      S_MOD: begin
        if (stat_i.occ_zero) begin
          if (stat_i.out_ready) begin
            cmd_o   = '{op: OP_FAIL, fail_code: ST_NO_HEALTHY};
            state_d = S_IDLE;
          end
        end else if (stat_i.idx_ge_occ) begin
          cmd_o.op = OP_SUB;
        end else begin
          state_d = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (stat_i.scan_done) begin
          if (stat_i.out_ready) begin
            cmd_o   = '{op: OP_FAIL, fail_code: ST_NO_HEALTHY};
            state_d = S_IDLE;
          end
        end else if (stat_i.hit_healthy) begin
          if (stat_i.out_ready) begin
            cmd_o.op = OP_PICK;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_WRAP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/hrrr_datapath.sv =====
module hrrr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hrrr_pkg::req_word_t in_word_i,
  input  logic               out_stall_i,
  input  hrrr_pkg::dp_cmd_t  cmd_i,
  output hrrr_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  output hrrr_pkg::rsp_word_t out_word_o
);
  import hrrr_pkg::*;

  logic [31:0]           addr_q [MaxEntries];
  logic [15:0]           port_q [MaxEntries];
  logic [31:0]           conn_q [MaxEntries];
  logic [MaxEntries-1:0] healthy_q;

  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] hcnt_q, hcnt_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] idx_q, cnt_q;
  req_word_t       req_q;
  rsp_word_t       out_q, rsp_d;
  logic            out_valid_q;

  logic [IdxW-1:0] rd_idx, wr_idx;
  logic [31:0]     rd_addr, rd_conn, conn_inc;
  logic [15:0]     rd_port;
  logic            rd_healthy;
  logic [CntW-1:0] idx_inc, idx_wrap;
  logic            finish;

  assign rd_idx     = idx_q[IdxW-1:0];
  assign wr_idx     = occ_q[IdxW-1:0];
  assign rd_addr    = addr_q[rd_idx];
  assign rd_port    = port_q[rd_idx];
  assign rd_conn    = conn_q[rd_idx];
  assign rd_healthy = healthy_q[rd_idx];
  assign conn_inc   = (rd_conn == 32'hFFFF_FFFF) ? rd_conn : rd_conn + 32'd1;
  assign idx_inc    = idx_q + CntW'(1);
  assign idx_wrap   = (idx_inc == occ_q) ? '0 : idx_inc;

  assign stat_o.out_ready   = !out_valid_q || !out_stall_i;
  assign stat_o.is_full     = (occ_q == CntW'(MaxEntries));
  assign stat_o.occ_zero    = (occ_q == '0);
  assign stat_o.idx_ge_occ  = (idx_q >= occ_q);
  assign stat_o.scan_done   = (cnt_q == occ_q);
  assign stat_o.hit_match   = (rd_addr == req_q.host_addr) && (rd_port == req_q.host_port);
  assign stat_o.hit_healthy = rd_healthy;

  always_comb begin
    occ_d  = occ_q;
    hcnt_d = hcnt_q;
    ptr_d  = ptr_q;
    finish = 1'b0;
    case (cmd_i.op)
      OP_ADD: begin
        occ_d  = occ_q + CntW'(1);
        hcnt_d = hcnt_q + CntW'(1);
        finish = 1'b1;
      end
      OP_HEALTH: begin
        hcnt_d = hcnt_q - CntW'(rd_healthy) + CntW'(req_q.is_healthy);
        finish = 1'b1;
      end
      OP_DELETE: begin
        occ_d  = occ_q - CntW'(1);
        hcnt_d = hcnt_q - CntW'(rd_healthy);
        finish = 1'b1;
      end
      OP_PICK: begin
        ptr_d  = idx_wrap[IdxW-1:0];
        finish = 1'b1;
      end
      OP_FAIL: finish = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    rsp_d                    = '0;
    rsp_d.status             = (cmd_i.op == OP_FAIL) ? cmd_i.fail_code : ST_OK;
    rsp_d.healthy_total      = 5'(hcnt_d);
    rsp_d.entry_total        = 5'(occ_d);
    if (cmd_i.op == OP_PICK) begin
      rsp_d.chosen_addr        = rd_addr;
      rsp_d.chosen_port        = rd_port;
      rsp_d.chosen_index       = 4'(rd_idx);
      rsp_d.chosen_connections = conn_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      hcnt_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      hcnt_q <= hcnt_d;
      ptr_q  <= ptr_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= rsp_d;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        req_q <= in_word_i;
        cnt_q <= '0;
        case (in_word_i.req_type)
          REQ_HEALTH: idx_q <= CntW'(in_word_i.entry_index);
          REQ_ROUTE:  idx_q <= CntW'(ptr_q);
          default:    idx_q <= '0;
        endcase
      end
      OP_SUB:  idx_q <= idx_q - occ_q;
      OP_NEXT: idx_q <= idx_inc;
      OP_WRAP: begin
        idx_q <= idx_wrap;
        cnt_q <= cnt_q + CntW'(1);
      end
      OP_ADD: begin
        addr_q[wr_idx]    <= req_q.host_addr;
        port_q[wr_idx]    <= req_q.host_port;
        conn_q[wr_idx]    <= '0;
        healthy_q[wr_idx] <= 1'b1;
      end
      OP_HEALTH: healthy_q[rd_idx] <= req_q.is_healthy;
      OP_DELETE: begin
        for (int k = 0; k < MaxEntries - 1; k++) begin
          if (IdxW'(k) >= rd_idx) begin
            addr_q[k]    <= addr_q[k+1];
            port_q[k]    <= port_q[k+1];
            conn_q[k]    <= conn_q[k+1];
            healthy_q[k] <= healthy_q[k+1];
          end
        end
      end
      OP_PICK: conn_q[rd_idx] <= conn_inc;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/healthy_replica_round_robin.sv =====
// channel | direction | handshake              | word
// request | in        | in_valid_i, in_stall_o  | req_word_t
// result  | out       | out_valid_o, out_stall_i| rsp_word_t
//
// One request at a time; the table is a flip-flop array read through one scan index.
// Add and health load the request, then finish; route on an empty table loads, then fails.
// Remove scans from entry 0 up to the match, or past the last entry when none matches.
// Route reduces the pointer by repeated subtraction of the entry count, then skips unhealthy entries.
// Reset clears entry count, route pointer and healthy count; entries need no clearing.
// A held result stalls the finishing step only; the table is not touched until it moves.
module healthy_replica_round_robin (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrrr_pkg::req_word_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrrr_pkg::rsp_word_t out_word_o
);
  import hrrr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  hrrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_word_i.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  hrrr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = busy;

endmodule
